// ----- sv/cpa_pkg.sv -----
// constants, types and the reciprocal divide shared by the cascaded period averager
`default_nettype none

package cpa_pkg;

    localparam int SAMPLE_SECONDS = 1;
    localparam int SAMPLES_PER_MINUTE =
        (SAMPLE_SECONDS < 1 || SAMPLE_SECONDS > 60) ? 1 : 60 / SAMPLE_SECONDS;
    localparam int MINUTES_PER_HOUR = 60;
    localparam int HOURS_PER_DAY = 24;

    localparam int AVG_W = 15;
    localparam int SUM_W = 21;
    localparam int HSUM_W = 20;
    localparam int SCNT_W = 6;
    localparam int MCNT_W = 6;
    localparam int HCNT_W = 5;

    // exact floor division of any 21-bit dividend by a divisor up to 64, while the quotient fits in 15 bits
    localparam int DIV_SHIFT = SUM_W + 6;
    localparam int RECIP_W = DIV_SHIFT + 1;
    localparam logic [RECIP_W-1:0] RECIP_MINUTE =
        RECIP_W'((2 ** DIV_SHIFT + SAMPLES_PER_MINUTE - 1) / SAMPLES_PER_MINUTE);
    localparam logic [RECIP_W-1:0] RECIP_HOUR =
        RECIP_W'((2 ** DIV_SHIFT + MINUTES_PER_HOUR - 1) / MINUTES_PER_HOUR);
    localparam logic [RECIP_W-1:0] RECIP_DAY =
        RECIP_W'((2 ** DIV_SHIFT + HOURS_PER_DAY - 1) / HOURS_PER_DAY);

    // input register and six work stages, the last of which is the output register
    localparam int STAGES = 7;

    typedef struct packed {
        logic [AVG_W-1:0] sample;
        logic [AVG_W-1:0] minute_avg;
        logic [AVG_W-1:0] hour_avg;
        logic [AVG_W-1:0] day_avg;
        logic             minute_done;
        logic             hour_done;
        logic             day_done;
        logic [SUM_W-1:0] acc;
    } item_t;

    function automatic logic [AVG_W-1:0] recip_div(
        input logic [SUM_W-1:0]   x,
        input logic [RECIP_W-1:0] recip
    );
        logic [SUM_W+RECIP_W-1:0] prod;
        prod = {{RECIP_W{1'b0}}, x} * {{SUM_W{1'b0}}, recip};
        return prod[DIV_SHIFT +: AVG_W];
    endfunction

endpackage

`default_nettype wire

// ----- sv/cpa_if.sv -----
// valid/ready channels for load samples and averaged results
`default_nettype none

interface cpa_sample_if
    import cpa_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [AVG_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface cpa_result_if
    import cpa_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [AVG_W-1:0] latest_sample;
    logic [AVG_W-1:0] minute_avg;
    logic [AVG_W-1:0] hour_avg;
    logic [AVG_W-1:0] day_avg;
    logic             minute_done;
    logic             hour_done;
    logic             day_done;

    modport source (
        output valid, output latest_sample, output minute_avg, output hour_avg,
        output day_avg, output minute_done, output hour_done, output day_done,
        input ready
    );
    modport sink (
        input valid, input latest_sample, input minute_avg, input hour_avg,
        input day_avg, input minute_done, input hour_done, input day_done,
        output ready
    );
endinterface

`default_nettype wire

// ----- sv/cascaded_period_averager.sv -----
// cascaded minute, hour and day averager of a fixed-point load signal
//
//   channel   modport  payload
//   samples   sink     sample (15b, q.8)
//   results   source   latest_sample, minute_avg, hour_avg, day_avg, *_done
//
// one sample per cycle sustained while results.ready holds
// the three sum/divide levels each take an add stage and a reciprocal multiply stage
// rst_n clears all sums, counts, held averages and the pipeline valid bits
// a stalled result holds only the stages behind it; empty stages keep filling
`default_nettype none

module cascaded_period_averager
    import cpa_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    cpa_sample_if.sink  samples,
    cpa_result_if.source results
);

    item_t              pipe_reg [STAGES];
    item_t              step [STAGES-1];
    logic [STAGES-1:0]  valid_reg;
    logic [STAGES-1:0]  stage_ready;
    logic [STAGES-2:0]  fire;

    logic [SCNT_W-1:0]  sample_count_reg, sample_count_next;
    logic [MCNT_W-1:0]  minute_count_reg, minute_count_next;
    logic [HCNT_W-1:0]  hour_count_reg, hour_count_next;
    logic [SUM_W-1:0]   sample_sum_reg, sample_sum_next;
    logic [SUM_W-1:0]   minute_sum_reg, minute_sum_next;
    logic [HSUM_W-1:0]  hour_sum_reg, hour_sum_next;
    logic [AVG_W-1:0]   held_minute_reg, held_minute_next;
    logic [AVG_W-1:0]   held_hour_reg, held_hour_next;
    logic [AVG_W-1:0]   held_day_reg, held_day_next;

    logic [SUM_W-1:0]   sample_sum_add;
    logic [SUM_W-1:0]   minute_sum_add;
    logic [HSUM_W-1:0]  hour_sum_add;
    logic [AVG_W-1:0]   minute_q, hour_q, day_q;
    logic               minute_end, hour_end, day_end;

    // ready ripples back from the output through any empty stage
    always_comb
    begin
        stage_ready[STAGES-1] = !valid_reg[STAGES-1] || results.ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
        for (int k = 0; k < STAGES - 1; k++)
        begin
            fire[k] = valid_reg[k] && stage_ready[k+1];
        end
    end

    assign samples.ready = stage_ready[0];

    // minute level: accumulate, then divide
    assign sample_sum_add = sample_sum_reg + SUM_W'(pipe_reg[0].sample);
    assign minute_end = (7'(sample_count_reg) + 7'd1) >= 7'(SAMPLES_PER_MINUTE);
    assign minute_q = recip_div(pipe_reg[1].acc, RECIP_MINUTE);

    // hour level
    assign minute_sum_add = minute_sum_reg + SUM_W'(pipe_reg[2].minute_avg);
    assign hour_end = (7'(minute_count_reg) + 7'd1) >= 7'(MINUTES_PER_HOUR);
    assign hour_q = recip_div(pipe_reg[3].acc, RECIP_HOUR);

    // day level
    assign hour_sum_add = hour_sum_reg + HSUM_W'(pipe_reg[4].hour_avg);
    assign day_end = (6'(hour_count_reg) + 6'd1) >= 6'(HOURS_PER_DAY);
    assign day_q = recip_div(SUM_W'(pipe_reg[5].acc), RECIP_DAY);

    always_comb
    begin
        for (int k = 0; k < STAGES - 1; k++)
        begin
            step[k] = pipe_reg[k];
        end

        step[0].acc = sample_sum_add;
        step[0].minute_done = minute_end;

        step[1].minute_avg = pipe_reg[1].minute_done ? minute_q : held_minute_reg;

        step[2].acc = minute_sum_add;
        step[2].hour_done = pipe_reg[2].minute_done && hour_end;

        step[3].hour_avg = pipe_reg[3].hour_done ? hour_q : held_hour_reg;

        step[4].acc = SUM_W'(hour_sum_add);
        step[4].day_done = pipe_reg[4].hour_done && day_end;

        step[5].day_avg = pipe_reg[5].day_done ? day_q : held_day_reg;
    end

    always_comb
    begin
        sample_count_next = sample_count_reg;
        sample_sum_next = sample_sum_reg;
        held_minute_next = held_minute_reg;
        minute_count_next = minute_count_reg;
        minute_sum_next = minute_sum_reg;
        held_hour_next = held_hour_reg;
        hour_count_next = hour_count_reg;
        hour_sum_next = hour_sum_reg;
        held_day_next = held_day_reg;

        if (fire[0])
        begin
            sample_count_next = minute_end ? '0 : sample_count_reg + 1'b1;
            sample_sum_next = minute_end ? '0 : sample_sum_add;
        end
        if (fire[1] && pipe_reg[1].minute_done)
        begin
            held_minute_next = minute_q;
        end
        if (fire[2] && pipe_reg[2].minute_done)
        begin
            minute_count_next = hour_end ? '0 : minute_count_reg + 1'b1;
            minute_sum_next = hour_end ? '0 : minute_sum_add;
        end
        if (fire[3] && pipe_reg[3].hour_done)
        begin
            held_hour_next = hour_q;
        end
        if (fire[4] && pipe_reg[4].hour_done)
        begin
            hour_count_next = day_end ? '0 : hour_count_reg + 1'b1;
            hour_sum_next = day_end ? '0 : hour_sum_add;
        end
        if (fire[5] && pipe_reg[5].day_done)
        begin
            held_day_next = day_q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            sample_count_reg <= '0;
            sample_sum_reg <= '0;
            held_minute_reg <= '0;
            minute_count_reg <= '0;
            minute_sum_reg <= '0;
            held_hour_reg <= '0;
            hour_count_reg <= '0;
            hour_sum_reg <= '0;
            held_day_reg <= '0;
        end
        else
        begin
            if (stage_ready[0])
            begin
                valid_reg[0] <= samples.valid;
            end
            for (int k = 1; k < STAGES; k++)
            begin
                if (stage_ready[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
            sample_count_reg <= sample_count_next;
            sample_sum_reg <= sample_sum_next;
            held_minute_reg <= held_minute_next;
            minute_count_reg <= minute_count_next;
            minute_sum_reg <= minute_sum_next;
            held_hour_reg <= held_hour_next;
            hour_count_reg <= hour_count_next;
            hour_sum_reg <= hour_sum_next;
            held_day_reg <= held_day_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (samples.valid && stage_ready[0])
        begin
            pipe_reg[0].sample <= samples.sample;
            pipe_reg[0].minute_avg <= '0;
            pipe_reg[0].hour_avg <= '0;
            pipe_reg[0].day_avg <= '0;
            pipe_reg[0].minute_done <= 1'b0;
            pipe_reg[0].hour_done <= 1'b0;
            pipe_reg[0].day_done <= 1'b0;
            pipe_reg[0].acc <= '0;
        end
        for (int k = 1; k < STAGES; k++)
        begin
            if (fire[k-1])
            begin
                pipe_reg[k] <= step[k-1];
            end
        end
    end

    assign results.valid = valid_reg[STAGES-1];
    assign results.latest_sample = pipe_reg[STAGES-1].sample;
    assign results.minute_avg = pipe_reg[STAGES-1].minute_avg;
    assign results.hour_avg = pipe_reg[STAGES-1].hour_avg;
    assign results.day_avg = pipe_reg[STAGES-1].day_avg;
    assign results.minute_done = pipe_reg[STAGES-1].minute_done;
    assign results.hour_done = pipe_reg[STAGES-1].hour_done;
    assign results.day_done = pipe_reg[STAGES-1].day_done;

`ifndef SYNTHESIS
    a_hour_needs_minute: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.hour_done |-> results.minute_done)
        else $error("hour completed without a minute");

    a_day_needs_hour: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.day_done |-> results.hour_done)
        else $error("day completed without an hour");

    a_sample_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        7'(sample_count_reg) < 7'(SAMPLES_PER_MINUTE))
        else $error("sample count past end of minute");

    a_level_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        7'(minute_count_reg) < 7'(MINUTES_PER_HOUR)
        && 6'(hour_count_reg) < 6'(HOURS_PER_DAY))
        else $error("minute or hour count past end of period");
`endif

endmodule

`default_nettype wire
